// ===== hdl/sjs_pkg.sv =====
// shared types, constants and q16.16 helpers for the vertex skinning block
package sjs_pkg;

   localparam int BASE_WORDS  = 7;
   localparam int FRAME_WORDS = 10;

   // word offsets inside a joint's base pose and a joint frame's pose
   localparam int BASE_T  = 0;
   localparam int BASE_R  = 3;
   localparam int FRAME_T = 0;
   localparam int FRAME_R = 3;
   localparam int FRAME_S = 7;

   localparam logic [0:0] REG_FRAME_COUNT = 1'b0;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_SKIN = 1'b1;

   localparam int PW = 48;
   localparam int SW = 52;
   localparam int DW = 48;
   localparam int NW = 49;

   typedef logic signed [31:0]   word_type;
   typedef logic signed [PW-1:0] prod_type;
   typedef logic signed [SW-1:0] sum_type;
   typedef word_type [2:0]       vec3_type;
   typedef word_type [3:0]       quat_type;

   typedef struct packed {
      logic            action;
      logic [5:0]      joint_index;
      logic [15:0]     frame_index;
      logic [4:0]      pose_slot;
      logic signed [31:0] pose_value;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] nrm_x;
      logic signed [31:0] nrm_y;
      logic signed [31:0] nrm_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_pos_x;
      logic signed [31:0] out_pos_y;
      logic signed [31:0] out_pos_z;
      logic signed [31:0] out_nrm_x;
      logic signed [31:0] out_nrm_y;
      logic signed [31:0] out_nrm_z;
   } rsp_type;

   typedef struct packed {
      vec3_type p;
      vec3_type nrm;
      vec3_type ft;
      quat_type fr;
   } side_type;

   typedef struct packed {
      side_type        side;
      quat_type        br;
      logic [NW-1:0]   norm;
   } div_in_type;

   typedef struct packed {
      side_type side;
      quat_type inv;
   } rot_in_type;

   localparam sum_type SAT_HI = 52'sd2147483647;
   localparam sum_type SAT_LO = -52'sd2147483648;

   // floored q16.16 product
   function automatic prod_type pm(input word_type a, input word_type b);
      logic signed [63:0] full;
      full = 64'(a) * 64'(b);
      return full[63:16];
   endfunction

   function automatic sum_type ext_p(input prod_type v);
      return SW'(v);
   endfunction

   function automatic sum_type ext_w(input word_type v);
      return SW'(v);
   endfunction

   function automatic word_type sat32(input sum_type v);
      word_type r;
      if (v > SAT_HI) begin
         r = 32'sh7fffffff;
      end else if (v < SAT_LO) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ===== hdl/sjs_ram.sv =====
// generic single-port-write ram with registered read
module sjs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic                                  re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ===== hdl/sjs_front.sv =====
// front stages: frame wrap, pose table access, scaled position and norm
module sjs_front #(
   parameter int MAX_JOINTS = 64,
   parameter int MAX_FRAMES = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [4:0]          divisor,
   input  logic                in_valid,
   output logic                in_ready,
   input  sjs_pkg::req_type    in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output sjs_pkg::div_in_type out_data
);
   import sjs_pkg::*;

   localparam int JW  = MAX_JOINTS > 1 ? $clog2(MAX_JOINTS) : 1;
   localparam int FD  = MAX_JOINTS * MAX_FRAMES;
   localparam int FAW = FD > 1 ? $clog2(FD) : 1;
   localparam int ST  = 5;

   function automatic logic [4:0] rem_steps(input logic [4:0] r, input logic [7:0] bits,
                                            input logic [4:0] d);
      logic [5:0] t;
      logic [4:0] acc;
      acc = r;
      for (int i = 7; i >= 0; i--) begin
         t = {acc, bits[i]};
         if (t >= {1'b0, d}) begin
            t = t - {1'b0, d};
         end
         acc = t[4:0];
      end
      return acc;
   endfunction

   logic [ST-1:0] v_ff;
   logic [ST:0]   en;

   req_type          req0_ff, req1_ff;
   logic [JW-1:0]    joint0_ff, joint1_ff;
   logic [4:0]       rem0_ff, frame1_ff;
   logic [FAW-1:0]   faddr;
   logic             wr;

   word_type  base_rd  [BASE_WORDS];
   word_type  frame_rd [FRAME_WORDS];
   word_type  pos2_ff  [3];
   word_type  nrm2_ff  [3];

   prod_type  spr3_ff [3];
   prod_type  sq3_ff  [4];
   word_type  bt3_ff  [3];
   word_type  nrm3_ff [3];
   word_type  ft3_ff  [3];
   word_type  br3_ff  [4];
   word_type  fr3_ff  [4];

   div_in_type out_ff;

   always_comb begin
      en[ST] = out_ready;
      for (int k = ST - 1; k >= 0; k--) begin
         en[k] = ~v_ff[k] | en[k+1];
      end
   end

   assign in_ready = en[0];
   assign faddr = FAW'(int'(joint1_ff) * MAX_FRAMES + int'(frame1_ff));
   assign wr = en[2] & v_ff[1] & (req1_ff.action == ACT_LOAD);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= in_valid;
         if (en[1]) v_ff[1] <= v_ff[0];
         if (en[2]) v_ff[2] <= v_ff[1] & (req1_ff.action == ACT_SKIN);
         if (en[3]) v_ff[3] <= v_ff[2];
         if (en[4]) v_ff[4] <= v_ff[3];
      end
   end

   for (genvar i = 0; i < BASE_WORDS; i++) begin : g_base
      sjs_ram #(.WIDTH(32), .DEPTH(MAX_JOINTS)) u_ram (
         .clock (clock),
         .we    (wr && (int'(req1_ff.pose_slot) == i)),
         .waddr (joint1_ff),
         .wdata (req1_ff.pose_value),
         .re    (en[2]),
         .raddr (joint1_ff),
         .rdata (base_rd[i])
      );
   end

   for (genvar i = 0; i < FRAME_WORDS; i++) begin : g_frame
      sjs_ram #(.WIDTH(32), .DEPTH(FD)) u_ram (
         .clock (clock),
         .we    (wr && (int'(req1_ff.pose_slot) == BASE_WORDS + i)),
         .waddr (faddr),
         .wdata (req1_ff.pose_value),
         .re    (en[2]),
         .raddr (faddr),
         .rdata (frame_rd[i])
      );
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         req0_ff   <= in_data;
         joint0_ff <= JW'(in_data.joint_index % MAX_JOINTS);
         rem0_ff   <= rem_steps(5'd0, in_data.frame_index[15:8], divisor);
      end
      if (en[1]) begin
         req1_ff   <= req0_ff;
         joint1_ff <= joint0_ff;
         frame1_ff <= rem_steps(rem0_ff, req0_ff.frame_index[7:0], divisor);
      end
      if (en[2]) begin
         pos2_ff[0] <= req1_ff.pos_x;
         pos2_ff[1] <= req1_ff.pos_y;
         pos2_ff[2] <= req1_ff.pos_z;
         nrm2_ff[0] <= req1_ff.nrm_x;
         nrm2_ff[1] <= req1_ff.nrm_y;
         nrm2_ff[2] <= req1_ff.nrm_z;
      end
      if (en[3]) begin
         for (int i = 0; i < 3; i++) begin
            spr3_ff[i] <= pm(pos2_ff[i], frame_rd[FRAME_S + i]);
            bt3_ff[i]  <= base_rd[BASE_T + i];
            nrm3_ff[i] <= nrm2_ff[i];
            ft3_ff[i]  <= frame_rd[FRAME_T + i];
         end
         for (int i = 0; i < 4; i++) begin
            sq3_ff[i] <= pm(base_rd[BASE_R + i], base_rd[BASE_R + i]);
            br3_ff[i] <= base_rd[BASE_R + i];
            fr3_ff[i] <= frame_rd[FRAME_R + i];
         end
      end
      if (en[4]) begin
         for (int i = 0; i < 3; i++) begin
            out_ff.side.p[i]   <= sat32(ext_w(sat32(ext_p(spr3_ff[i]))) - ext_w(bt3_ff[i]));
            out_ff.side.nrm[i] <= nrm3_ff[i];
            out_ff.side.ft[i]  <= ft3_ff[i];
         end
         for (int i = 0; i < 4; i++) begin
            out_ff.side.fr[i] <= fr3_ff[i];
            out_ff.br[i]      <= br3_ff[i];
         end
         out_ff.norm <= NW'(sq3_ff[0][46:0]) + NW'(sq3_ff[1][46:0])
                      + NW'(sq3_ff[2][46:0]) + NW'(sq3_ff[3][46:0]);
      end
   end

   assign out_valid = v_ff[ST-1];
   assign out_data  = out_ff;
endmodule

// ===== hdl/sjs_qinv.sv =====
// pipelined quaternion inverse: one quotient bit per stage over four lanes
module sjs_qinv (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  sjs_pkg::div_in_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output sjs_pkg::rot_in_type out_data
);
   import sjs_pkg::*;

   localparam int DS = DW;
   localparam int ST = DS + 1;

   typedef struct packed {
      logic [NW-1:0] rem;
      logic [DW-1:0] dq;
   } step_type;

   function automatic step_type div_step(input logic [NW-1:0] r, input logic [DW-1:0] d,
                                         input logic [NW-1:0] n);
      logic [NW:0] t;
      step_type    s;
      t = {r, d[DW-1]};
      if (t >= {1'b0, n}) begin
         t    = t - {1'b0, n};
         s.dq = {d[DW-2:0], 1'b1};
      end else begin
         s.dq = {d[DW-2:0], 1'b0};
      end
      s.rem = t[NW-1:0];
      return s;
   endfunction

   logic [ST-1:0]  v_ff;
   logic [ST:0]    en;

   side_type       side_ff [ST];
   quat_type       br_ff   [DS];
   logic [NW-1:0]  norm_ff [DS];
   logic [3:0]     neg_ff  [DS];
   step_type       step_ff [DS][4];
   step_type       step_in [DS][4];
   quat_type       inv_ff;
   quat_type       inv_in;
   logic [DW-1:0]  init_dq [4];
   logic [3:0]     init_neg;

   always_comb begin
      en[ST] = out_ready;
      for (int k = ST - 1; k >= 0; k--) begin
         en[k] = ~v_ff[k] | en[k+1];
      end
   end

   assign in_ready = en[0];

   always_comb begin
      logic [31:0] c;
      for (int l = 0; l < 4; l++) begin
         c = in_data.br[l];
         init_dq[l]  = {(c[31] ? (~c + 32'd1) : c), 16'd0};
         init_neg[l] = (l == 3) ? c[31] : ~c[31];
      end
   end

   always_comb begin
      for (int l = 0; l < 4; l++) begin
         step_in[0][l] = div_step('0, init_dq[l], in_data.norm);
         for (int k = 1; k < DS; k++) begin
            step_in[k][l] = div_step(step_ff[k-1][l].rem, step_ff[k-1][l].dq, norm_ff[k-1]);
         end
      end
   end

   always_comb begin
      logic [DW-1:0] q;
      for (int l = 0; l < 4; l++) begin
         q = step_ff[DS-1][l].dq;
         if (norm_ff[DS-1] == '0) begin
            inv_in[l] = br_ff[DS-1][l];
         end else if (neg_ff[DS-1][l]) begin
            inv_in[l] = (q > DW'(64'h80000000)) ? 32'sh80000000 : (~q[31:0] + 32'd1);
         end else begin
            inv_in[l] = (q > DW'(64'h7fffffff)) ? 32'sh7fffffff : q[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= (en[ST-1:0] & {v_ff[ST-2:0], in_valid}) | (~en[ST-1:0] & v_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         side_ff[0] <= in_data.side;
         br_ff[0]   <= in_data.br;
         norm_ff[0] <= in_data.norm;
         neg_ff[0]  <= init_neg;
         step_ff[0] <= step_in[0];
      end
      for (int k = 1; k < DS; k++) begin
         if (en[k]) begin
            side_ff[k] <= side_ff[k-1];
            br_ff[k]   <= br_ff[k-1];
            norm_ff[k] <= norm_ff[k-1];
            neg_ff[k]  <= neg_ff[k-1];
            step_ff[k] <= step_in[k];
         end
      end
      if (en[DS]) begin
         side_ff[DS] <= side_ff[DS-1];
         inv_ff      <= inv_in;
      end
   end

   assign out_valid     = v_ff[ST-1];
   assign out_data.side = side_ff[DS];
   assign out_data.inv  = inv_ff;
endmodule

// ===== hdl/sjs_rot.sv =====
// rotation stages: quaternion product, rotation matrix, vector rotate, translate
module sjs_rot (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  sjs_pkg::rot_in_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output sjs_pkg::rsp_type    out_data
);
   import sjs_pkg::*;

   localparam int ST = 7;
   localparam int XX = 0, YY = 1, ZZ = 2, WW = 3, XY = 4;
   localparam int XZ = 5, YZ = 6, WX = 7, WY = 8, WZ = 9;

   logic [ST-1:0] v_ff;
   logic [ST:0]   en;

   side_type  side_ff [5];
   prod_type  pr0_ff  [4][4];
   word_type  rq1_ff  [4];
   prod_type  sp2_ff  [10];
   word_type  m3_ff   [9];
   prod_type  pp4_ff  [3][3];
   prod_type  np4_ff  [3][3];
   word_type  t5_ff   [3];
   word_type  rn5_ff  [3];
   word_type  ft5_ff  [3];
   rsp_type   rsp_ff;

   function automatic sum_type dbl(input prod_type v);
      return ext_p(v) + ext_p(v);
   endfunction

   always_comb begin
      en[ST] = out_ready;
      for (int k = ST - 1; k >= 0; k--) begin
         en[k] = ~v_ff[k] | en[k+1];
      end
   end

   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= (en[ST-1:0] & {v_ff[ST-2:0], in_valid}) | (~en[ST-1:0] & v_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         side_ff[0] <= in_data.side;
         for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
               pr0_ff[i][j] <= pm(in_data.side.fr[i], in_data.inv[j]);
            end
         end
      end
      if (en[1]) begin
         side_ff[1] <= side_ff[0];
         rq1_ff[0] <= sat32(ext_p(pr0_ff[0][3]) + ext_p(pr0_ff[3][0])
                          + ext_p(pr0_ff[1][2]) - ext_p(pr0_ff[2][1]));
         rq1_ff[1] <= sat32(ext_p(pr0_ff[1][3]) + ext_p(pr0_ff[3][1])
                          + ext_p(pr0_ff[2][0]) - ext_p(pr0_ff[0][2]));
         rq1_ff[2] <= sat32(ext_p(pr0_ff[2][3]) + ext_p(pr0_ff[3][2])
                          + ext_p(pr0_ff[0][1]) - ext_p(pr0_ff[1][0]));
         rq1_ff[3] <= sat32(ext_p(pr0_ff[3][3]) - ext_p(pr0_ff[0][0])
                          - ext_p(pr0_ff[1][1]) - ext_p(pr0_ff[2][2]));
      end
      if (en[2]) begin
         side_ff[2] <= side_ff[1];
         sp2_ff[XX] <= pm(rq1_ff[0], rq1_ff[0]);
         sp2_ff[YY] <= pm(rq1_ff[1], rq1_ff[1]);
         sp2_ff[ZZ] <= pm(rq1_ff[2], rq1_ff[2]);
         sp2_ff[WW] <= pm(rq1_ff[3], rq1_ff[3]);
         sp2_ff[XY] <= pm(rq1_ff[0], rq1_ff[1]);
         sp2_ff[XZ] <= pm(rq1_ff[0], rq1_ff[2]);
         sp2_ff[YZ] <= pm(rq1_ff[1], rq1_ff[2]);
         sp2_ff[WX] <= pm(rq1_ff[3], rq1_ff[0]);
         sp2_ff[WY] <= pm(rq1_ff[3], rq1_ff[1]);
         sp2_ff[WZ] <= pm(rq1_ff[3], rq1_ff[2]);
      end
      if (en[3]) begin
         side_ff[3] <= side_ff[2];
         m3_ff[0] <= sat32(ext_p(sp2_ff[XX]) + ext_p(sp2_ff[WW])
                         - ext_p(sp2_ff[YY]) - ext_p(sp2_ff[ZZ]));
         m3_ff[1] <= sat32(dbl(sp2_ff[XY]) - dbl(sp2_ff[WZ]));
         m3_ff[2] <= sat32(dbl(sp2_ff[XZ]) + dbl(sp2_ff[WY]));
         m3_ff[3] <= sat32(dbl(sp2_ff[WZ]) + dbl(sp2_ff[XY]));
         m3_ff[4] <= sat32(ext_p(sp2_ff[WW]) - ext_p(sp2_ff[XX])
                         + ext_p(sp2_ff[YY]) - ext_p(sp2_ff[ZZ]));
         m3_ff[5] <= sat32(dbl(sp2_ff[YZ]) - dbl(sp2_ff[WX]));
         m3_ff[6] <= sat32(dbl(sp2_ff[XZ]) - dbl(sp2_ff[WY]));
         m3_ff[7] <= sat32(dbl(sp2_ff[WX]) + dbl(sp2_ff[YZ]));
         m3_ff[8] <= sat32(ext_p(sp2_ff[WW]) - ext_p(sp2_ff[XX])
                         - ext_p(sp2_ff[YY]) + ext_p(sp2_ff[ZZ]));
      end
      if (en[4]) begin
         side_ff[4] <= side_ff[3];
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               pp4_ff[i][j] <= pm(side_ff[3].p[j], m3_ff[3*i + j]);
               np4_ff[i][j] <= pm(side_ff[3].nrm[j], m3_ff[3*i + j]);
            end
         end
      end
      if (en[5]) begin
         for (int i = 0; i < 3; i++) begin
            t5_ff[i]  <= sat32(ext_p(pp4_ff[i][0]) + ext_p(pp4_ff[i][1])
                             + ext_p(pp4_ff[i][2]));
            rn5_ff[i] <= sat32(ext_p(np4_ff[i][0]) + ext_p(np4_ff[i][1])
                             + ext_p(np4_ff[i][2]));
            ft5_ff[i] <= side_ff[4].ft[i];
         end
      end
      if (en[6]) begin
         rsp_ff.out_pos_x <= sat32(ext_w(t5_ff[0]) + ext_w(ft5_ff[0]));
         rsp_ff.out_pos_y <= sat32(ext_w(t5_ff[1]) + ext_w(ft5_ff[1]));
         rsp_ff.out_pos_z <= sat32(ext_w(t5_ff[2]) + ext_w(ft5_ff[2]));
         rsp_ff.out_nrm_x <= rn5_ff[0];
         rsp_ff.out_nrm_y <= rn5_ff[1];
         rsp_ff.out_nrm_z <= rn5_ff[2];
      end
   end

   assign out_valid = v_ff[ST-1];
   assign out_data  = rsp_ff;
endmodule

// ===== hdl/single_joint_vertex_skinning.sv =====
// top level of the single-joint quaternion vertex skinning pipeline
// throughput: one word per cycle unless rsp_ready holds it back; the 48-stage inverse divider sets the depth
// req_ready drops only when every stage holds a word and the result waits
// reset clears all stage valids and sets frame_count to 1
// pose tables have no reset value; the user must write them before reading, the block does not enforce it
module single_joint_vertex_skinning #(
   parameter int MAX_JOINTS = 64,
   parameter int MAX_FRAMES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sjs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sjs_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import sjs_pkg::*;

   logic [4:0] frame_count_ff, frame_count_in;
   logic [4:0] divisor;
   logic       csr_write;

   logic       f_valid, f_ready, q_valid, q_ready;
   div_in_type f_data;
   rot_in_type q_data;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready & (paddr[2:2] == REG_FRAME_COUNT);

   always_comb begin
      frame_count_in = csr_write ? pwdata[4:0] : frame_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= 5'd1;
      end else begin
         frame_count_ff <= frame_count_in;
      end
   end

   assign prdata = (paddr[2:2] == REG_FRAME_COUNT) ? {27'd0, frame_count_ff} : 32'd0;

   always_comb begin
      if (frame_count_ff == 5'd0) begin
         divisor = 5'd1;
      end else if (int'(frame_count_ff) > MAX_FRAMES) begin
         divisor = 5'(MAX_FRAMES);
      end else begin
         divisor = frame_count_ff;
      end
   end

   sjs_front #(.MAX_JOINTS(MAX_JOINTS), .MAX_FRAMES(MAX_FRAMES)) u_front (
      .clock     (clock),
      .reset     (reset),
      .divisor   (divisor),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_data  (f_data)
   );

   sjs_qinv u_qinv (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (f_data),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_data)
   );

   sjs_rot u_rot (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .in_data   (q_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );
endmodule

// ===== hdl/sjs_checker.sv =====
// port-level checker for the vertex skinning block and its bind
module sjs_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input sjs_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input sjs_pkg::rsp_type rsp_data,
   input logic             psel,
   input logic             penable,
   input logic             pwrite,
   input logic [2:0]       paddr,
   input logic [31:0]      pwdata,
   input logic [31:0]      prdata,
   input logic             pready
);
   a_full_only_when_stalled: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled while the result side is free");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   a_pready: assert property (@(posedge clock) pready)
      else $error("pready low");

   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite && pready && (paddr[2] == 1'b0)
      |=> (paddr[2] != 1'b0) || (prdata == {27'd0, $past(pwdata[4:0])}))
      else $error("frame count readback mismatch");

   a_reset_clears: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");
endmodule

bind single_joint_vertex_skinning sjs_checker u_sjs_checker (.*);

// ===== sim/single_joint_vertex_skinning_checker.sv =====
// result checker for the vertex skinning block: mirrors the pose tables and predicts each result
module single_joint_vertex_skinning_checker #(
   parameter int MAX_JOINTS = 64,
   parameter int MAX_FRAMES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  sjs_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  sjs_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   input  logic             pready,
   output int               failures,
   output int               pending
);
   import sjs_pkg::*;

   typedef word_type [8:0] mat_type;

   word_type        base_tab[MAX_JOINTS*BASE_WORDS];
   word_type        frame_tab[MAX_JOINTS*MAX_FRAMES*FRAME_WORDS];
   logic [4:0]      frame_count_q;
   rsp_type         skinned_q[$];

   function automatic word_type clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return word_type'(v[31:0]);
   endfunction

   function automatic longint fmul(input word_type a, input word_type b);
      longint p;
      p = longint'(a) * longint'(b);
      return p >>> 16;
   endfunction

   function automatic word_type div_comp(input word_type c, input longint n, input bit negate);
      longint mag;
      longint q;
      bit neg;
      mag = (c < 0) ? -longint'(c) : longint'(c);
      q = (mag <<< 16) / n;
      neg = (c < 0) != negate;
      return clamp32(neg ? -q : q);
   endfunction

   function automatic quat_type quat_inverse(input quat_type q);
      longint n;
      quat_type r;
      n = fmul(q[0], q[0]) + fmul(q[1], q[1]) + fmul(q[2], q[2]) + fmul(q[3], q[3]);
      if (n <= 0) return q;
      r[0] = div_comp(q[0], n, 1'b1);
      r[1] = div_comp(q[1], n, 1'b1);
      r[2] = div_comp(q[2], n, 1'b1);
      r[3] = div_comp(q[3], n, 1'b0);
      return r;
   endfunction

   function automatic quat_type quat_mul(input quat_type a, input quat_type b);
      quat_type r;
      r[0] = clamp32(fmul(a[0], b[3]) + fmul(a[3], b[0]) + fmul(a[1], b[2]) - fmul(a[2], b[1]));
      r[1] = clamp32(fmul(a[1], b[3]) + fmul(a[3], b[1]) + fmul(a[2], b[0]) - fmul(a[0], b[2]));
      r[2] = clamp32(fmul(a[2], b[3]) + fmul(a[3], b[2]) + fmul(a[0], b[1]) - fmul(a[1], b[0]));
      r[3] = clamp32(fmul(a[3], b[3]) - fmul(a[0], b[0]) - fmul(a[1], b[1]) - fmul(a[2], b[2]));
      return r;
   endfunction

   function automatic mat_type quat_matrix(input quat_type q);
      longint xx, yy, zz, ww, xy, xz, yz, wx, wy, wz;
      mat_type m;
      xx = fmul(q[0], q[0]); yy = fmul(q[1], q[1]);
      zz = fmul(q[2], q[2]); ww = fmul(q[3], q[3]);
      xy = fmul(q[0], q[1]); xz = fmul(q[0], q[2]); yz = fmul(q[1], q[2]);
      wx = fmul(q[3], q[0]); wy = fmul(q[3], q[1]); wz = fmul(q[3], q[2]);
      m[0] = clamp32(xx + ww - yy - zz);
      m[1] = clamp32(2 * xy - 2 * wz);
      m[2] = clamp32(2 * xz + 2 * wy);
      m[3] = clamp32(2 * wz + 2 * xy);
      m[4] = clamp32(ww - xx + yy - zz);
      m[5] = clamp32(2 * yz - 2 * wx);
      m[6] = clamp32(2 * xz - 2 * wy);
      m[7] = clamp32(2 * wx + 2 * yz);
      m[8] = clamp32(ww - xx - yy + zz);
      return m;
   endfunction

   function automatic vec3_type mat_apply(input vec3_type v, input mat_type m);
      vec3_type r;
      for (int i = 0; i < 3; i++) begin
         r[i] = clamp32(fmul(v[0], m[3*i]) + fmul(v[1], m[3*i+1]) + fmul(v[2], m[3*i+2]));
      end
      return r;
   endfunction

   // applies one word to the mirrored tables, returns 1 when it yields a vertex
   function automatic bit skin_word(input req_type w, output rsp_type res);
      int fc, frame, bo, fo;
      quat_type br, fr, rq;
      mat_type m;
      vec3_type p, n, t, rn;
      word_type s;
      fc = frame_count_q;
      if (fc == 0) fc = 1;
      if (fc > MAX_FRAMES) fc = MAX_FRAMES;
      frame = w.frame_index % fc;
      bo = (w.joint_index % MAX_JOINTS) * BASE_WORDS;
      fo = ((w.joint_index % MAX_JOINTS) * MAX_FRAMES + frame) * FRAME_WORDS;
      res = '0;
      if (w.action != ACT_SKIN) begin
         if (w.pose_slot < BASE_WORDS) base_tab[bo + w.pose_slot] = w.pose_value;
         else if (w.pose_slot < BASE_WORDS + FRAME_WORDS)
            frame_tab[fo + w.pose_slot - BASE_WORDS] = w.pose_value;
         return 1'b0;
      end
      for (int i = 0; i < 4; i++) begin
         br[i] = base_tab[bo + BASE_R + i];
         fr[i] = frame_tab[fo + FRAME_R + i];
      end
      rq = quat_mul(fr, quat_inverse(br));
      m = quat_matrix(rq);
      p[0] = w.pos_x; p[1] = w.pos_y; p[2] = w.pos_z;
      n[0] = w.nrm_x; n[1] = w.nrm_y; n[2] = w.nrm_z;
      for (int i = 0; i < 3; i++) begin
         s = clamp32(fmul(p[i], frame_tab[fo + FRAME_S + i]));
         p[i] = clamp32(longint'(s) - longint'(base_tab[bo + BASE_T + i]));
      end
      t = mat_apply(p, m);
      rn = mat_apply(n, m);
      res.out_pos_x = clamp32(longint'(t[0]) + longint'(frame_tab[fo + FRAME_T]));
      res.out_pos_y = clamp32(longint'(t[1]) + longint'(frame_tab[fo + FRAME_T + 1]));
      res.out_pos_z = clamp32(longint'(t[2]) + longint'(frame_tab[fo + FRAME_T + 2]));
      res.out_nrm_x = rn[0];
      res.out_nrm_y = rn[1];
      res.out_nrm_z = rn[2];
      return 1'b1;
   endfunction

   task automatic compare_field(input string name, input word_type want, input word_type got);
      if (want !== got) begin
         $display("%0t mismatch %s expected %h actual %h", $time, name, want, got);
         failures++;
      end
   endtask

   initial begin
      failures = 0;
      pending = 0;
      frame_count_q = 5'd1;
   end

   always @(posedge clock) begin
      rsp_type res;
      rsp_type want;
      if (reset) begin
         frame_count_q = 5'd1;
         skinned_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (skinned_q.size() == 0) begin
               $display("%0t unexpected vertex word %h", $time, rsp_data);
               failures++;
            end else begin
               want = skinned_q.pop_front();
               compare_field("out_pos_x", want.out_pos_x, rsp_data.out_pos_x);
               compare_field("out_pos_y", want.out_pos_y, rsp_data.out_pos_y);
               compare_field("out_pos_z", want.out_pos_z, rsp_data.out_pos_z);
               compare_field("out_nrm_x", want.out_nrm_x, rsp_data.out_nrm_x);
               compare_field("out_nrm_y", want.out_nrm_y, rsp_data.out_nrm_y);
               compare_field("out_nrm_z", want.out_nrm_z, rsp_data.out_nrm_z);
            end
         end
         if (req_valid && req_ready) begin
            if (skin_word(req_data, res)) skinned_q.push_back(res);
         end
         if (psel && penable && pwrite && pready && paddr[2] == REG_FRAME_COUNT)
            frame_count_q = pwdata[4:0];
      end
      pending = skinned_q.size();
   end

endmodule

// ===== sim/single_joint_vertex_skinning_tb.sv =====
// testbench top for the vertex skinning block: stimulus, flow control and verdict
module single_joint_vertex_skinning_tb;
   import sjs_pkg::*;

   localparam logic [0:0] REG_UNUSED = 1'b1;
   localparam int SLOT_COUNT = BASE_WORDS + FRAME_WORDS;
   localparam int CYCLE_LIMIT = 600000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;
   int          failures;
   int          pending;

   int          tx_idle_pct;
   int          rx_idle_pct;
   bit          hold_asked;
   int          eff_frames;
   int          cycles;
   bit          base_ok[64][BASE_WORDS];
   bit          frame_ok[64][16][FRAME_WORDS];

   single_joint_vertex_skinning u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   single_joint_vertex_skinning_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready), .failures(failures), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // receiver flow control, with a long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_asked) begin
            hold_asked = 1'b0;
            hold_left = 600;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   function automatic word_type any_word();
      return word_type'($urandom());
   endfunction

   function automatic word_type edge_word();
      case ($urandom_range(3))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return 32'sh0;
         default: return 32'shffffffff;
      endcase
   endfunction

   // mostly near unit magnitude so rotations stay meaningful
   function automatic word_type pose_word();
      int r;
      r = $urandom_range(9);
      if (r < 6) return word_type'($urandom_range(131072) - 65536);
      if (r < 8) return word_type'($urandom_range(512) - 256);
      if (r < 9) return any_word();
      return edge_word();
   endfunction

   function automatic word_type coord_word();
      int r;
      r = $urandom_range(9);
      if (r < 7) return word_type'($urandom_range(8388608) - 4194304);
      if (r < 9) return any_word();
      return edge_word();
   endfunction

   function automatic int wrap_frame(input logic [15:0] f);
      return f % eff_frames;
   endfunction

   function automatic bit pose_ready(input int j, input int f);
      for (int i = 0; i < BASE_WORDS; i++) if (!base_ok[j][i]) return 1'b0;
      for (int i = 0; i < FRAME_WORDS; i++) if (!frame_ok[j][f][i]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic logic [15:0] raw_frame(input int f);
      int k;
      k = $urandom_range((65535 - f) / eff_frames);
      return 16'(f + k * eff_frames);
   endfunction

   function automatic req_type random_req();
      logic [255:0] raw;
      raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
             $urandom(), $urandom(), $urandom()};
      return raw[$bits(req_type)-1:0];
   endfunction

   task automatic send_word(input req_type w);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (!req_ready);
      if (w.action == ACT_LOAD) begin
         if (w.pose_slot < BASE_WORDS) base_ok[w.joint_index][w.pose_slot] = 1'b1;
         else if (w.pose_slot < SLOT_COUNT)
            frame_ok[w.joint_index][wrap_frame(w.frame_index)][w.pose_slot - BASE_WORDS] = 1'b1;
      end
   endtask

   task automatic load_slot(input int j, input logic [15:0] f, input int slot,
                            input word_type v);
      req_type w;
      w = random_req();
      w.action = ACT_LOAD;
      w.joint_index = 6'(j);
      w.frame_index = f;
      w.pose_slot = 5'(slot);
      w.pose_value = v;
      send_word(w);
   endtask

   task automatic skin_vertex(input int j, input logic [15:0] f, input vec3_type p,
                              input vec3_type n);
      req_type w;
      w = random_req();
      w.action = ACT_SKIN;
      w.joint_index = 6'(j);
      w.frame_index = f;
      w.pos_x = p[0]; w.pos_y = p[1]; w.pos_z = p[2];
      w.nrm_x = n[0]; w.nrm_y = n[1]; w.nrm_z = n[2];
      send_word(w);
   endtask

   task automatic csr_write(input logic [0:0] idx, input logic [31:0] v);
      @(posedge clock);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= {idx, 2'b00}; pwdata <= v;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (idx == REG_FRAME_COUNT) begin
         eff_frames = v[4:0];
         if (eff_frames == 0) eff_frames = 1;
         if (eff_frames > 16) eff_frames = 16;
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (80) @(posedge clock);
   endtask

   task automatic random_run(input int n_items);
      int sent, j, f, reps;
      vec3_type p, n;
      sent = 0;
      while (sent < n_items) begin
         j = $urandom_range(63);
         f = $urandom_range(eff_frames - 1);
         if ($urandom_range(9) == 0) begin
            // ignored slot or a single stray rewrite
            if ($urandom_range(1)) load_slot(j, raw_frame(f), $urandom_range(31, SLOT_COUNT),
                                            any_word());
            else begin
               load_slot(j, raw_frame(f), $urandom_range(SLOT_COUNT - 1), pose_word());
               sent++;
            end
         end else begin
            if (!pose_ready(j, f) || $urandom_range(3) == 0) begin
               for (int s = 0; s < SLOT_COUNT; s++) load_slot(j, raw_frame(f), s, pose_word());
               sent += SLOT_COUNT;
            end
            reps = $urandom_range(12, 1);
            for (int r = 0; r < reps; r++) begin
               if (pose_ready(j, f)) begin
                  for (int i = 0; i < 3; i++) begin
                     p[i] = coord_word();
                     n[i] = pose_word();
                  end
                  skin_vertex(j, raw_frame(f), p, n);
                  sent++;
               end
            end
         end
      end
   endtask

   initial begin
      vec3_type p, n;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
      hold_asked = 1'b0;
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      eff_frames = 1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: identity pose, extremes, ignored slot, zero-norm base rotation
      csr_write(REG_FRAME_COUNT, 32'd16);
      csr_write(REG_UNUSED, 32'd3);
      for (int s = 0; s < SLOT_COUNT; s++)
         load_slot(63, 16'd65535, s, (s == BASE_R + 3 || s == BASE_WORDS + FRAME_R + 3 ||
                                      s >= BASE_WORDS + FRAME_S) ? 32'sd65536 : 32'sd0);
      p = {32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
      n = {32'sh80000000, 32'sh7fffffff, 32'sh0};
      skin_vertex(63, 16'd15, p, n);
      skin_vertex(63, 16'd65535, n, p);
      load_slot(63, 16'd15, 31, 32'sh7fffffff);
      for (int s = BASE_R; s < BASE_R + 4; s++) load_slot(63, 16'd31, s, 32'sd0);
      p = {32'sd65536, -32'sd131072, 32'sd0};
      skin_vertex(63, 16'd47, p, p);
      drain();

      csr_write(REG_FRAME_COUNT, 32'd1);
      tx_idle_pct = 11; rx_idle_pct = 84;
      random_run(150);
      drain();
      random_run(150);
      drain();

      csr_write(REG_FRAME_COUNT, 32'd0);
      tx_idle_pct = 84; rx_idle_pct = 11;
      random_run(300);
      drain();

      csr_write(REG_FRAME_COUNT, 32'd31);
      tx_idle_pct = 0; rx_idle_pct = 0;
      hold_asked = 1'b1;
      random_run(300);
      drain();

      csr_write(REG_FRAME_COUNT, 32'd7);
      random_run(300);
      drain();

      if (failures == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
